// ===== hdl/hpve_pkg.sv =====
// Shared types and constants for the Hall period velocity estimator.
// Used by the divider, datapath, controller and top level; no dependencies.
`timescale 1ns / 1ps

package hpve_pkg;

	// Field widths.
	localparam int MODE_W   = 2;
	localparam int FLAGS_W  = 3;
	localparam int CAP_W    = 16;
	localparam int SUM_W    = 16;
	localparam int CNT_W    = 8;
	localparam int PER_W    = 24;
	localparam int RPM_W    = 16;
	localparam int CPP_W    = 16;
	localparam int NUM_W    = 32;
	localparam int LIM_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	// Shared divider: NUM_W-bit dividend, PER_W-bit divisor, one quotient bit per cycle.
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Constants of the estimator.
	localparam logic [PER_W-1:0] PERIOD_MAX   = PER_W'(65534) << 8;
	localparam logic [RPM_W-1:0] RPM_SAT      = 16'hFFFF;
	localparam logic [CNT_W-1:0] SAMPLE_MAX   = 8'd255;
	localparam logic [PER_W-1:0] FIX24_MAX    = 24'hFFFFFF;

	// Configuration reset values.
	localparam logic [CPP_W-1:0] CPP_RESET    = 16'd655;
	localparam logic [NUM_W-1:0] RPM_NUM_RESET = 32'd83886080;
	localparam logic [LIM_W-1:0] LIM_RESET    = 8'd100;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CPP      = 2'd0,
		REG_RPM_NUM  = 2'd1,
		REG_STALL_LIM = 2'd2,
		REG_NONE     = 2'd3
	} cfg_idx_t;

	// Input word kinds.
	typedef enum logic [MODE_W-1:0] {
		MODE_CAPTURE = 2'd0,
		MODE_TICK    = 2'd1,
		MODE_RESTART = 2'd2,
		MODE_IDLE    = 2'd3
	} mode_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_STALL_MUL,
		ST_STALL_APPLY,
		ST_AVG_WAIT,
		ST_RPM_START,
		ST_RPM_WAIT,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic exec;
		logic div_start;
		logic div_rpm;
		logic stall_mul;
		logic stall_apply;
		logic avg_load;
		logic rpm_sat;
		logic rpm_load;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tick;
		logic tick_avg;
		logic period_zero;
		logic div_done;
	} dp_sts_t;

endpackage

// ===== hdl/hpve_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on hpve_pkg for the operand widths and step count.
`timescale 1ns / 1ps

module hpve_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hpve_pkg::NUM_W-1:0]  dividend,
	input  logic [hpve_pkg::PER_W-1:0]  divisor,
	output logic                        done,
	output logic [hpve_pkg::NUM_W-1:0]  quotient
);
	import hpve_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     dvd_q;
	logic [PER_W-1:0]     dsr_q;
	logic [PER_W:0]       rem_q;
	logic [PER_W:0]       trial;
	logic                 fits;

	// Shift the next dividend bit into the partial remainder and test it.
	assign trial = {rem_q[PER_W-1:0], dvd_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient bits enter the dividend register from the bottom as it empties.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
			dvd_q <= {dvd_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== hdl/hpve_dp.sv =====
// Datapath: estimator state, configuration registers, stall multiplier and output word.
// Depends on hpve_pkg and instantiates hpve_div.
`timescale 1ns / 1ps

module hpve_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hpve_pkg::dp_cmd_t                cmd,
	output hpve_pkg::dp_sts_t                sts,
	input  logic [hpve_pkg::MODE_W-1:0]      in_mode,
	input  logic [hpve_pkg::FLAGS_W-1:0]     in_flags,
	input  logic [hpve_pkg::CAP_W-1:0]       in_value,
	input  logic                             cfg_wr,
	input  logic [hpve_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hpve_pkg::CFG_DAT_W-1:0]   cfg_data,
	output logic [hpve_pkg::PER_W-1:0]       out_period,
	output logic [hpve_pkg::RPM_W-1:0]       out_rpm,
	output logic [hpve_pkg::CAP_W-1:0]       out_width,
	output logic                             out_ovf,
	output logic                             out_tclr
);
	import hpve_pkg::*;

	// Held input word.
	mode_t              mode_q;
	logic [FLAGS_W-1:0] flags_q;
	logic [CAP_W-1:0]   value_q;

	// Configuration.
	logic [CPP_W-1:0]   cpp_q;
	logic [NUM_W-1:0]   rpm_num_q;
	logic [LIM_W-1:0]   lim_q;

	// Estimator state.
	logic [CAP_W-1:0]   prev_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic [LIM_W-1:0]   stall_q;
	logic [PER_W-1:0]   period_q;
	logic [RPM_W-1:0]   rpm_q;
	logic [CAP_W-1:0]   width_q;
	logic               tclr_q;

	// Stall period intermediate.
	logic [PER_W-1:0]   prod_q;
	logic               lim_hit_q;

	logic               single_flag;
	logic [CAP_W-1:0]   new_width;
	logic [SUM_W:0]     new_sum;
	logic [PER_W-1:0]   stall_period;
	logic [NUM_W-1:0]   div_dividend;
	logic [PER_W-1:0]   div_divisor;
	logic               div_done;
	logic [NUM_W-1:0]   div_quot;

	assign single_flag = (flags_q == 3'b001) || (flags_q == 3'b010) || (flags_q == 3'b100);
	assign new_width   = value_q - prev_q;
	assign new_sum     = {1'b0, sum_q} + {1'b0, new_width};
	assign stall_period = (|prod_q[PER_W-1:SUM_W]) ? FIX24_MAX : {prod_q[SUM_W-1:0], 8'h00};

	assign div_dividend = cmd.div_rpm ? rpm_num_q : {8'h00, sum_q, 8'h00};
	assign div_divisor  = cmd.div_rpm ? period_q : {{(PER_W-CNT_W){1'b0}}, count_q};

	hpve_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		sts.is_tick     = (mode_q == MODE_TICK);
		sts.tick_avg    = !ovf_q && (count_q != '0);
		sts.period_zero = (period_q == '0);
		sts.div_done    = div_done;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q  <= mode_t'(in_mode);
			flags_q <= in_flags;
			value_q <= in_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpp_q     <= CPP_RESET;
			rpm_num_q <= RPM_NUM_RESET;
			lim_q     <= LIM_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx_t'(cfg_index))
				REG_CPP:       cpp_q     <= cfg_data[CPP_W-1:0];
				REG_RPM_NUM:   rpm_num_q <= cfg_data[NUM_W-1:0];
				REG_STALL_LIM: lim_q     <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.stall_mul) begin
			prod_q    <= PER_W'(stall_q) * PER_W'(cpp_q);
			lim_hit_q <= stall_q >= lim_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			sum_q    <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			stall_q  <= '0;
			period_q <= PERIOD_MAX;
			rpm_q    <= '0;
			width_q  <= '0;
			tclr_q   <= 1'b0;
		end else begin
			if (cmd.exec) begin
				tclr_q <= 1'b0;
				case (mode_q)
					MODE_CAPTURE: begin
						if (single_flag) begin
							width_q <= new_width;
							prev_q  <= value_q;
							if (count_q == SAMPLE_MAX || new_sum[SUM_W]) begin
								ovf_q   <= 1'b1;
								sum_q   <= '0;
								count_q <= '0;
							end else begin
								sum_q   <= new_sum[SUM_W-1:0];
								count_q <= count_q + 1'b1;
							end
						end else begin
							prev_q <= '0;
							tclr_q <= 1'b1;
						end
					end
					MODE_TICK: begin
						// If the divider is started in this cycle, it latches sum and count before they are cleared.
						if (!sts.tick_avg) begin
							stall_q <= stall_q + 1'b1;
						end
						ovf_q   <= 1'b0;
						sum_q   <= '0;
						count_q <= '0;
					end
					MODE_RESTART: begin
						ovf_q    <= 1'b0;
						sum_q    <= '0;
						count_q  <= '0;
						stall_q  <= '0;
						period_q <= PERIOD_MAX;
						rpm_q    <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.stall_apply) begin
				if (lim_hit_q) begin
					period_q <= PERIOD_MAX;
				end else if (stall_period > period_q) begin
					period_q <= stall_period;
				end
			end
			if (cmd.avg_load) begin
				period_q <= div_quot[PER_W-1:0];
				stall_q  <= '0;
			end
			if (cmd.rpm_sat) begin
				rpm_q <= RPM_SAT;
			end
			if (cmd.rpm_load) begin
				rpm_q <= (|div_quot[NUM_W-1:RPM_W]) ? RPM_SAT : div_quot[RPM_W-1:0];
			end
		end
	end

	// Output word register, loaded once per item.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_period <= period_q;
			out_rpm    <= rpm_q;
			out_width  <= width_q;
			out_ovf    <= ovf_q;
			out_tclr   <= tclr_q;
		end
	end

endmodule

// ===== hdl/hpve_ctrl.sv =====
// Controller state machine: sequences each input word through the datapath.
// Depends on hpve_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps

module hpve_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output hpve_pkg::dp_cmd_t  cmd,
	input  hpve_pkg::dp_sts_t  sts
);
	import hpve_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:        if (in_valid) state_nxt = ST_EXEC;
			ST_EXEC: begin
				if (!sts.is_tick) state_nxt = ST_DONE;
				else if (sts.tick_avg) state_nxt = ST_AVG_WAIT;
				else state_nxt = ST_STALL_MUL;
			end
			ST_STALL_MUL:   state_nxt = ST_STALL_APPLY;
			ST_STALL_APPLY: state_nxt = ST_RPM_START;
			ST_AVG_WAIT:    if (sts.div_done) state_nxt = ST_RPM_START;
			ST_RPM_START:   state_nxt = sts.period_zero ? ST_DONE : ST_RPM_WAIT;
			ST_RPM_WAIT:    if (sts.div_done) state_nxt = ST_DONE;
			ST_DONE:        if (out_free) state_nxt = ST_IDLE;
			default:        state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:        cmd.load_in = in_valid;
			ST_EXEC: begin
				cmd.exec      = 1'b1;
				cmd.div_start = sts.is_tick && sts.tick_avg;
			end
			ST_STALL_MUL:   cmd.stall_mul = 1'b1;
			ST_STALL_APPLY: cmd.stall_apply = 1'b1;
			ST_AVG_WAIT:    cmd.avg_load = sts.div_done;
			ST_RPM_START: begin
				cmd.rpm_sat   = sts.period_zero;
				cmd.div_start = !sts.period_zero;
				cmd.div_rpm   = 1'b1;
			end
			ST_RPM_WAIT: begin
				cmd.div_rpm  = 1'b1;
				cmd.rpm_load = sts.div_done;
			end
			ST_DONE:        cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/hall_period_velocity_estimator_core.sv =====
// Top level of the Hall period velocity estimator: controller plus datapath.
// Depends on hpve_pkg, hpve_ctrl, hpve_dp and hpve_div.
//
// Usage. The slave stream takes one word per Hall capture event, control tick or
// restart command; tuser carries the kind. Every accepted word yields exactly one
// result word on the master stream showing the estimator state after that word.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data and are
// always ready; they should only be written while no word is in flight.
//
// Sequencing. A capture, restart or unused word passes through the execute and
// done states from acceptance to a loaded result. A control tick runs through one
// shared serial divider, one quotient bit each cycle: an averaging tick needs two
// divisions, a stall tick one division, fewer when the period is zero. The divider
// sets the tick rate; the next word can be accepted in the cycle after a result is
// loaded.
//
// Reset puts the estimator in its startup state (period 65534.0 counts, rpm 0) and
// the configuration at its defaults. A stalled receiver holds the result in the
// output register; the block still accepts and processes the next word and only
// waits before loading its result if the previous one has not been taken.
`timescale 1ns / 1ps

module hall_period_velocity_estimator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] capture_flags, [18:3] capture_value, [23:19] zero
	input  logic [23:0] s_axis_tdata,
	// [1:0] mode
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [23:0] average_period, [39:24] average_rpm, [55:40] relative_count
	output logic [55:0] m_axis_tdata,
	// [0] overflow_seen, [1] timer_clear
	output logic [1:0]  m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import hpve_pkg::*;

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [PER_W-1:0] out_period;
	logic [RPM_W-1:0] out_rpm;
	logic [CAP_W-1:0] out_width;
	logic             out_ovf;
	logic             out_tclr;

	// Register writes complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	hpve_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	hpve_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_mode    (s_axis_tuser),
		.in_flags   (s_axis_tdata[FLAGS_W-1:0]),
		.in_value   (s_axis_tdata[FLAGS_W+CAP_W-1:FLAGS_W]),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_period (out_period),
		.out_rpm    (out_rpm),
		.out_width  (out_width),
		.out_ovf    (out_ovf),
		.out_tclr   (out_tclr)
	);

	assign m_axis_tdata = {out_width, out_rpm, out_period};
	assign m_axis_tuser = {out_tclr, out_ovf};

endmodule

// ===== hdl/hpve_chk.sv =====
// Port-level checker for the Hall period velocity estimator, bound to the top level.
// Depends on hall_period_velocity_estimator_core's port list.
`timescale 1ns / 1ps

module hpve_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        cfg_ready
);

	// One word at a time: the slave side closes right after an accept.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a word was in flight");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result word changed while stalled");

	// A zero period always reports saturated speed.
	a_zero_period_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[23:0] == 24'h000000)) |->
			(m_axis_tdata[39:24] == 16'hFFFF))
		else $error("zero period without saturated rpm");

	// Configuration writes are never back-pressured.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind hall_period_velocity_estimator_core hpve_chk u_hpve_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.cfg_ready     (cfg_ready)
);
